// ----- src/sfd_pkg.sv -----
// ----------------------------------------------------------------------------
// sfd_pkg
// Shared types and constants of the serial frame deframer
// ----------------------------------------------------------------------------
package sfd_pkg;

    localparam int MAX_PAYLOAD = 275;

    localparam int BYTE_W  = 8;
    localparam int KIND_W  = 2;
    localparam int POS_W   = 9;
    localparam int LEN_W   = 16;
    localparam int INDEX_W = 8;

    localparam logic [BYTE_W-1:0] START_MARKER_RESET = 8'd27;
    localparam logic [BYTE_W-1:0] TOKEN_MARKER_RESET = 8'd14;

    localparam logic [INDEX_W-1:0] REG_START_MARKER = 8'd0;
    localparam logic [INDEX_W-1:0] REG_TOKEN_MARKER = 8'd1;

    localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_PAYLOAD);

    typedef enum logic [KIND_W-1:0] {
        KIND_BYTE     = 2'd0,
        KIND_GOOD     = 2'd1,
        KIND_CKSUM    = 2'd2,
        KIND_OVERSIZE = 2'd3
    } kind_t;

    typedef enum logic [6:0] {
        PH_IDLE   = 7'b0000001,
        PH_SEQ    = 7'b0000010,
        PH_LEN_HI = 7'b0000100,
        PH_LEN_LO = 7'b0001000,
        PH_TOKEN  = 7'b0010000,
        PH_DATA   = 7'b0100000,
        PH_CHECK  = 7'b1000000
    } phase_t;

endpackage

// ----- src/sfd_in_if.sv -----
// ----------------------------------------------------------------------------
// sfd_in_if
// Received byte channel
// ----------------------------------------------------------------------------
interface sfd_in_if;
    import sfd_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] rx_value;

    modport source (output valid, output rx_value, input ready);
    modport sink (input valid, input rx_value, output ready);
endinterface

// ----- src/sfd_out_if.sv -----
// ----------------------------------------------------------------------------
// sfd_out_if
// Result channel: payload bytes and frame status
// ----------------------------------------------------------------------------
interface sfd_out_if;
    import sfd_pkg::*;

    logic              valid;
    logic              ready;
    kind_t             kind;
    logic [BYTE_W-1:0] payload_value;
    logic [POS_W-1:0]  payload_position;
    logic [BYTE_W-1:0] frame_sequence;
    logic [LEN_W-1:0]  frame_length;

    modport source (
        output valid, output kind, output payload_value, output payload_position,
        output frame_sequence, output frame_length, input ready
    );
    modport sink (
        input valid, input kind, input payload_value, input payload_position,
        input frame_sequence, input frame_length, output ready
    );
endinterface

// ----- src/sfd_cfg_if.sv -----
// ----------------------------------------------------------------------------
// sfd_cfg_if
// Register write channel
// ----------------------------------------------------------------------------
interface sfd_cfg_if;
    import sfd_pkg::*;

    logic               valid;
    logic               ready;
    logic [INDEX_W-1:0] index;
    logic [BYTE_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// ----- src/serial_frame_deframer_xor.sv -----
// ----------------------------------------------------------------------------
// serial_frame_deframer_xor
// Datapath: an accepted byte is held in the input reg, then its result in the result reg.
// Throughput: one byte per cycle, limited only by the result sink's ready.
// Reset: async active low; returns to idle, markers to 27 and 14, no result held.
// Parses start, sequence, length, token, payload and xor checksum of each frame.
// ----------------------------------------------------------------------------
module serial_frame_deframer_xor (
    input  logic       clk,
    input  logic       rst_n,
    sfd_in_if.sink     frame_in,
    sfd_out_if.source  frame_out,
    sfd_cfg_if.sink    cfg
);
    import sfd_pkg::*;

    logic [BYTE_W-1:0] start_marker_reg;
    logic [BYTE_W-1:0] token_marker_reg;

    logic              in_valid_reg;
    logic [BYTE_W-1:0] in_byte_reg;

    phase_t            phase_reg, phase_next;
    logic [BYTE_W-1:0] xor_reg, xor_next;
    logic [BYTE_W-1:0] seq_reg, seq_next;
    logic [LEN_W-1:0]  len_reg, len_next;
    logic [POS_W-1:0]  pos_reg, pos_next;

    logic              out_valid_reg;
    kind_t             kind_reg, kind_next;
    logic [BYTE_W-1:0] value_reg, value_next;
    logic [POS_W-1:0]  position_reg, position_next;
    logic [BYTE_W-1:0] out_seq_reg;
    logic [LEN_W-1:0]  out_len_reg;

    logic              has_result;
    logic              out_free;
    logic              proc_fire;
    logic [POS_W-1:0]  pos_inc;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_marker_reg <= START_MARKER_RESET;
            token_marker_reg <= TOKEN_MARKER_RESET;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_START_MARKER: start_marker_reg <= cfg.data;
                REG_TOKEN_MARKER: token_marker_reg <= cfg.data;
                default: ;
            endcase
        end
    end

    // a byte leaves the input register unless its result has nowhere to go
    assign out_free        = !out_valid_reg || frame_out.ready;
    assign proc_fire       = in_valid_reg && (!has_result || out_free);
    assign frame_in.ready  = !in_valid_reg || proc_fire;
    assign pos_inc         = pos_reg + POS_W'(1);

    always_comb
    begin
        phase_next    = phase_reg;
        xor_next      = xor_reg ^ in_byte_reg;
        seq_next      = seq_reg;
        len_next      = len_reg;
        pos_next      = pos_reg;
        has_result    = 1'b0;
        kind_next     = KIND_BYTE;
        value_next    = '0;
        position_next = '0;
        unique case (phase_reg)
            PH_SEQ:
            begin
                seq_next   = in_byte_reg;
                phase_next = PH_LEN_HI;
            end
            PH_LEN_HI:
            begin
                len_next   = {in_byte_reg, {BYTE_W{1'b0}}};
                phase_next = PH_LEN_LO;
            end
            PH_LEN_LO:
            begin
                len_next   = {len_reg[LEN_W-1:BYTE_W], in_byte_reg};
                phase_next = PH_TOKEN;
            end
            PH_TOKEN:
            begin
                if (in_byte_reg != token_marker_reg)
                begin
                    phase_next = PH_IDLE;
                end
                else if (len_reg > MAX_LEN)
                begin
                    has_result = 1'b1;
                    kind_next  = KIND_OVERSIZE;
                    phase_next = PH_IDLE;
                    xor_next   = '0;
                    seq_next   = '0;
                    len_next   = '0;
                    pos_next   = '0;
                end
                else
                begin
                    pos_next   = '0;
                    phase_next = (len_reg == '0) ? PH_CHECK : PH_DATA;
                end
            end
            PH_DATA:
            begin
                has_result    = 1'b1;
                kind_next     = KIND_BYTE;
                value_next    = in_byte_reg;
                position_next = pos_reg;
                pos_next      = pos_inc;
                if (LEN_W'(pos_inc) >= len_reg)
                begin
                    phase_next = PH_CHECK;
                end
            end
            PH_CHECK:
            begin
                has_result = 1'b1;
                kind_next  = ((in_byte_reg == xor_reg) && (len_reg != '0)) ? KIND_GOOD
                                                                           : KIND_CKSUM;
                phase_next = PH_IDLE;
                xor_next   = '0;
                seq_next   = '0;
                len_next   = '0;
                pos_next   = '0;
            end
            default:
            begin
                // idle, and any stray code behaves as idle
                xor_next   = xor_reg;
                phase_next = PH_IDLE;
                if (in_byte_reg == start_marker_reg)
                begin
                    xor_next   = in_byte_reg;
                    phase_next = PH_SEQ;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            phase_reg     <= PH_IDLE;
            xor_reg       <= '0;
            seq_reg       <= '0;
            len_reg       <= '0;
            pos_reg       <= '0;
        end
        else
        begin
            if (frame_in.ready)
            begin
                in_valid_reg <= frame_in.valid;
            end
            if (proc_fire)
            begin
                phase_reg <= phase_next;
                xor_reg   <= xor_next;
                seq_reg   <= seq_next;
                len_reg   <= len_next;
                pos_reg   <= pos_next;
            end
            if (out_free)
            begin
                out_valid_reg <= proc_fire && has_result;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (frame_in.valid && frame_in.ready)
        begin
            in_byte_reg <= frame_in.rx_value;
        end
        if (proc_fire && has_result)
        begin
            kind_reg     <= kind_next;
            value_reg    <= value_next;
            position_reg <= position_next;
            out_seq_reg  <= seq_reg;
            out_len_reg  <= len_reg;
        end
    end

    assign frame_out.valid            = out_valid_reg;
    assign frame_out.kind             = kind_reg;
    assign frame_out.payload_value    = value_reg;
    assign frame_out.payload_position = position_reg;
    assign frame_out.frame_sequence   = out_seq_reg;
    assign frame_out.frame_length     = out_len_reg;

endmodule
